@@ design/scre_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scre_pkg: shared definitions for the signed-count run-length encoder
// Constants, byte source codes and the command/status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package scre_pkg;

    // Coding limits and output packing.
    localparam int LIT_MAX   = 128;
    localparam int REP_MAX   = 127;
    localparam int OUT_LANES = 8;

    // Derived widths.
    localparam int LIT_AW    = $clog2(LIT_MAX);
    localparam int LIT_CW    = $clog2(LIT_MAX + 1);
    localparam int RUN_W     = $clog2(REP_MAX + 1);
    localparam int LANE_W    = $clog2(OUT_LANES);
    localparam int BCNT_W    = 4;
    localparam int BYTE_W    = 8;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 72;

    // Source of the byte handed to the output packer in a cycle.
    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_LIT_HDR,
        SEL_LIT_DATA,
        SEL_REP_CNT,
        SEL_REP_BYTE
    } byte_sel_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic      accept;
        logic      start_run;
        logic      split_run;
        logic      clear_run;
        logic      add_lit;
        byte_sel_t byte_sel;
        logic      finalize;
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic match;
        logic have_run;
        logic run_split;
        logic run_full;
        logic run_zero;
        logic run_one;
        logic eos;
        logic lit_empty;
        logic lit_last;
        logic flush_last;
        logic byte_ready;
        logic acc_empty;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

@@ design/scre_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scre_datapath: run state, literal store and output lane packer
// Holds the open run, the pending literal bytes in a small memory, and packs
// the emitted byte stream into results of up to eight bytes.
// ----------------------------------------------------------------------------
module scre_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire scre_pkg::dp_cmd_t              cmd,
    output scre_pkg::dp_status_t                status,
    input  wire logic [scre_pkg::BYTE_W-1:0]    s_data,
    input  wire logic                           s_last,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // Fields from bit 0: out_byte_0..out_byte_7, byte_count, zero pad.
    output logic [scre_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);

    // Latched input beat.
    logic [scre_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        eos_reg;

    // Open run.
    logic [scre_pkg::BYTE_W-1:0] run_byte_reg, run_byte_next;
    logic [scre_pkg::RUN_W-1:0]  run_len_reg, run_len_next;
    logic                        split_reg, split_next;
    logic                        have_run_reg, have_run_next;

    // Literal store and its flush pointer.
    logic [scre_pkg::BYTE_W-1:0] lit_mem [scre_pkg::LIT_MAX];
    logic [scre_pkg::BYTE_W-1:0] rd_data_reg;
    logic [scre_pkg::LIT_AW-1:0] rd_addr;
    logic [scre_pkg::LIT_CW-1:0] lit_cnt_reg, lit_cnt_next;
    logic [scre_pkg::LIT_AW-1:0] idx_reg, idx_next;

    // Lane packer: accumulating lanes and the output register.
    logic [scre_pkg::BYTE_W-1:0] acc_lane_reg [scre_pkg::OUT_LANES];
    logic [scre_pkg::BYTE_W-1:0] acc_lane_next [scre_pkg::OUT_LANES];
    logic [scre_pkg::BCNT_W-1:0] acc_cnt_reg, acc_cnt_next;
    logic [scre_pkg::BYTE_W-1:0] out_lane_reg [scre_pkg::OUT_LANES];
    logic [scre_pkg::BYTE_W-1:0] out_lane_next [scre_pkg::OUT_LANES];
    logic [scre_pkg::BCNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_valid_reg, out_valid_next;

    logic [scre_pkg::BYTE_W-1:0] emit_byte;
    logic                        emit_valid;
    logic                        out_free;
    logic                        byte_ready;
    logic                        acc_full;
    logic                        emit_take;

    localparam logic [scre_pkg::BCNT_W-1:0] ACC_FULL_CNT =
        scre_pkg::BCNT_W'(scre_pkg::OUT_LANES);

    // Packer back-pressure.
    assign out_free   = !out_valid_reg || m_tready;
    assign acc_full   = (acc_cnt_reg == ACC_FULL_CNT);
    assign byte_ready = !acc_full || out_free;
    assign emit_valid = (cmd.byte_sel != scre_pkg::SEL_NONE);
    assign emit_take  = emit_valid && byte_ready;

    // Byte source selection.
    always_comb begin
        case (cmd.byte_sel)
            scre_pkg::SEL_LIT_HDR:  emit_byte = 8'd0 - 8'(lit_cnt_reg);
            scre_pkg::SEL_LIT_DATA: emit_byte = rd_data_reg;
            scre_pkg::SEL_REP_CNT:  emit_byte = 8'(run_len_reg);
            scre_pkg::SEL_REP_BYTE: emit_byte = run_byte_reg;
            default:                emit_byte = '0;
        endcase
    end

    // Status toward the controller.
    always_comb begin
        status.match      = have_run_reg && (s_data == run_byte_reg);
        status.have_run   = have_run_reg;
        status.run_split  = split_reg;
        status.run_full   = (run_len_reg >= scre_pkg::RUN_W'(scre_pkg::REP_MAX));
        status.run_zero   = (run_len_reg == '0);
        status.run_one    = (run_len_reg == scre_pkg::RUN_W'(1));
        status.eos        = eos_reg;
        status.lit_empty  = (lit_cnt_reg == '0);
        status.lit_last   = (lit_cnt_reg == scre_pkg::LIT_CW'(scre_pkg::LIT_MAX - 1));
        status.flush_last = ((scre_pkg::LIT_CW'(idx_reg) + scre_pkg::LIT_CW'(1))
                             == lit_cnt_reg);
        status.byte_ready = byte_ready;
        status.acc_empty  = (acc_cnt_reg == '0);
        status.out_free   = out_free;
    end

    // Run state updates.
    always_comb begin
        run_byte_next = run_byte_reg;
        run_len_next  = run_len_reg;
        split_next    = split_reg;
        have_run_next = have_run_reg;
        if (cmd.accept && status.match) begin
            run_len_next = run_len_reg + scre_pkg::RUN_W'(1);
        end
        if (cmd.start_run) begin
            have_run_next = 1'b1;
            run_byte_next = in_byte_reg;
            run_len_next  = scre_pkg::RUN_W'(1);
            split_next    = 1'b0;
        end
        if (cmd.split_run) begin
            run_len_next = '0;
            split_next   = 1'b1;
        end
        if (cmd.clear_run) begin
            have_run_next = 1'b0;
            run_len_next  = '0;
            split_next    = 1'b0;
        end
    end

    // Literal count and flush pointer; the read address runs one ahead when
    // a data byte is taken so the registered read keeps pace.
    always_comb begin
        lit_cnt_next = lit_cnt_reg;
        idx_next     = idx_reg;
        rd_addr      = idx_reg;
        if (cmd.add_lit) begin
            lit_cnt_next = lit_cnt_reg + scre_pkg::LIT_CW'(1);
        end
        if (cmd.byte_sel == scre_pkg::SEL_LIT_HDR) begin
            idx_next = '0;
            rd_addr  = '0;
        end else if ((cmd.byte_sel == scre_pkg::SEL_LIT_DATA) && byte_ready) begin
            idx_next = idx_reg + scre_pkg::LIT_AW'(1);
            rd_addr  = idx_reg + scre_pkg::LIT_AW'(1);
            if (status.flush_last) begin
                lit_cnt_next = '0;
            end
        end
    end

    // Lane packer: a full lane set moves out when the next byte arrives, so
    // the final result of a burst can still be marked.
    always_comb begin
        acc_lane_next  = acc_lane_reg;
        acc_cnt_next   = acc_cnt_reg;
        out_lane_next  = out_lane_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (emit_take || cmd.finalize) begin
            if (acc_full || cmd.finalize) begin
                out_valid_next = 1'b1;
                out_cnt_next   = acc_cnt_reg;
                out_last_next  = cmd.finalize;
                for (int j = 0; j < scre_pkg::OUT_LANES; j++) begin
                    out_lane_next[j] = (scre_pkg::BCNT_W'(j) < acc_cnt_reg) ?
                                       acc_lane_reg[j] : '0;
                end
                acc_cnt_next = '0;
            end
            if (emit_take) begin
                if (acc_full) begin
                    acc_lane_next[0] = emit_byte;
                    acc_cnt_next     = scre_pkg::BCNT_W'(1);
                end else begin
                    acc_lane_next[acc_cnt_reg[scre_pkg::LANE_W-1:0]] = emit_byte;
                    acc_cnt_next = acc_cnt_reg + scre_pkg::BCNT_W'(1);
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_byte_reg  <= '0;
            run_len_reg   <= '0;
            split_reg     <= 1'b0;
            have_run_reg  <= 1'b0;
            lit_cnt_reg   <= '0;
            idx_reg       <= '0;
            acc_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            run_byte_reg  <= run_byte_next;
            run_len_reg   <= run_len_next;
            split_reg     <= split_next;
            have_run_reg  <= have_run_next;
            lit_cnt_reg   <= lit_cnt_next;
            idx_reg       <= idx_next;
            acc_cnt_reg   <= acc_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_byte_reg <= s_data;
            eos_reg     <= s_last;
        end
        acc_lane_reg <= acc_lane_next;
        out_lane_reg <= out_lane_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
    end

    // Literal store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.add_lit) begin
            lit_mem[lit_cnt_reg[scre_pkg::LIT_AW-1:0]] <= run_byte_reg;
        end
        rd_data_reg <= lit_mem[rd_addr];
    end

    // Result beat.
    always_comb begin
        m_tdata = '0;
        for (int j = 0; j < scre_pkg::OUT_LANES; j++) begin
            m_tdata[j*scre_pkg::BYTE_W +: scre_pkg::BYTE_W] = out_lane_reg[j];
        end
        m_tdata[scre_pkg::OUT_LANES*scre_pkg::BYTE_W +: scre_pkg::BCNT_W] = out_cnt_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

@@ design/scre_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scre_ctrl: encoder sequencer
// Walks each input beat through run extension, run close, chunk split and
// end-of-stream flush, and steps the datapath through byte emission.
// ----------------------------------------------------------------------------
module scre_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire scre_pkg::dp_status_t status,
    output scre_pkg::dp_cmd_t         cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CLOSE    = 4'd1;
    localparam logic [3:0] ST_START    = 4'd2;
    localparam logic [3:0] ST_POST     = 4'd3;
    localparam logic [3:0] ST_SPLIT    = 4'd4;
    localparam logic [3:0] ST_FINAL    = 4'd5;
    localparam logic [3:0] ST_END      = 4'd6;
    localparam logic [3:0] ST_FL_HDR   = 4'd7;
    localparam logic [3:0] ST_FL_DATA  = 4'd8;
    localparam logic [3:0] ST_REP_CNT  = 4'd9;
    localparam logic [3:0] ST_REP_BYTE = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [3:0] cont_reg, cont_next;   // where a run close continues
    logic [3:0] ret_reg, ret_next;     // where a repeat chunk returns
    logic [3:0] post_reg, post_next;   // where a literal flush returns

    // No beat is taken while reset is held.
    assign s_tready = (state_reg == ST_IDLE) && aresetn;

    always_comb begin
        state_next = state_reg;
        cont_next  = cont_reg;
        ret_next   = ret_reg;
        post_next  = post_reg;
        cmd        = '0;
        cmd.byte_sel = scre_pkg::SEL_NONE;

        case (state_reg)
            // Take a beat; a matching byte just extends the run.
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.accept = 1'b1;
                    if (status.match) begin
                        state_next = ST_POST;
                    end else begin
                        cont_next  = ST_START;
                        state_next = ST_CLOSE;
                    end
                end
            end

            // Close the open run: repeat chunk, literal, or nothing.
            ST_CLOSE: begin
                if (status.have_run && ((status.run_split && !status.run_zero) ||
                                        (!status.run_split && !status.run_one))) begin
                    ret_next = cont_reg;
                    if (!status.lit_empty) begin
                        post_next  = ST_REP_CNT;
                        state_next = ST_FL_HDR;
                    end else begin
                        state_next = ST_REP_CNT;
                    end
                end else begin
                    if (status.have_run && !status.run_split) begin
                        cmd.add_lit = 1'b1;
                    end
                    if (status.have_run && !status.run_split && status.lit_last) begin
                        post_next  = cont_reg;
                        state_next = ST_FL_HDR;
                    end else if (cont_reg == ST_START) begin
                        cmd.start_run = 1'b1;
                        state_next    = ST_POST;
                    end else begin
                        state_next = ST_FINAL;
                    end
                end
            end

            ST_START: begin
                cmd.start_run = 1'b1;
                state_next    = ST_POST;
            end

            // Full chunk, end of stream, or done with this beat.
            ST_POST: begin
                if (status.run_full) begin
                    ret_next = ST_SPLIT;
                    if (!status.lit_empty) begin
                        post_next  = ST_REP_CNT;
                        state_next = ST_FL_HDR;
                    end else begin
                        state_next = ST_REP_CNT;
                    end
                end else if (status.eos) begin
                    cont_next  = ST_FINAL;
                    state_next = ST_CLOSE;
                end else begin
                    state_next = ST_END;
                end
            end

            ST_SPLIT: begin
                cmd.split_run = 1'b1;
                state_next    = ST_POST;
            end

            // End of stream: drop the run and flush what is left.
            ST_FINAL: begin
                cmd.clear_run = 1'b1;
                if (!status.lit_empty) begin
                    post_next  = ST_END;
                    state_next = ST_FL_HDR;
                end else begin
                    state_next = ST_END;
                end
            end

            // Push the lanes still held, full or not, as the final result of the burst.
            ST_END: begin
                if (status.acc_empty) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.finalize = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            ST_FL_HDR: begin
                cmd.byte_sel = scre_pkg::SEL_LIT_HDR;
                if (status.byte_ready) begin
                    state_next = ST_FL_DATA;
                end
            end

            ST_FL_DATA: begin
                cmd.byte_sel = scre_pkg::SEL_LIT_DATA;
                if (status.byte_ready && status.flush_last) begin
                    state_next = post_reg;
                end
            end

            ST_REP_CNT: begin
                cmd.byte_sel = scre_pkg::SEL_REP_CNT;
                if (status.byte_ready) begin
                    state_next = ST_REP_BYTE;
                end
            end

            ST_REP_BYTE: begin
                cmd.byte_sel = scre_pkg::SEL_REP_BYTE;
                if (status.byte_ready) begin
                    state_next = ret_reg;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cont_reg  <= ST_START;
            ret_reg   <= ST_POST;
            post_reg  <= ST_END;
        end else begin
            state_reg <= state_next;
            cont_reg  <= cont_next;
            ret_reg   <= ret_next;
            post_reg  <= post_next;
        end
    end

endmodule
`default_nettype wire

@@ design/signed_count_rle_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_count_rle_encoder: signed-count run-length encoder
// One raw byte per input beat, encoded bytes packed up to eight per result.
// ----------------------------------------------------------------------------
// One byte is taken at a time and processed to completion before the next is
// accepted. A byte that extends the open run passes through the post and end
// states; a byte that starts a new run first closes the old run. The sequencer
// hands one encoded byte per cycle to the lane packer while it is ready, and
// the literal store has a single read port (a literal flush sends a header,
// then the stored bytes). End-of-stream and chunk handling have own states,
// and the sequencer waits while the result register is held by back-pressure.
// Bytes of one input beat leave as results of eight bytes, with the last,
// possibly shorter, result flagged by m_tlast.
// ----------------------------------------------------------------------------
module signed_count_rle_encoder (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0: data_byte.
    input  wire logic [scre_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // Fields from bit 0: out_byte_0..out_byte_7, byte_count, zero pad.
    output logic [scre_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tlast
);

    scre_pkg::dp_cmd_t    cmd;
    scre_pkg::dp_status_t status;

    // Sequencer.
    scre_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Run state, literal store and packer.
    scre_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_data   (s_tdata[scre_pkg::BYTE_W-1:0]),
        .s_last   (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // A result always carries one to eight bytes.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[67:64] != 4'd0) && (m_tdata[67:64] <= 4'd8))
        else $error("result byte count out of range");

    // Only the final result of a burst may be short.
    a_full_unless_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[67:64] == 4'd8))
        else $error("short result not marked last");

    // An accepted byte is always worked on before the next: s_tready falls after each accept.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted back to back");

    // No encoded byte is produced while waiting for input.
    a_no_emit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.byte_sel != scre_pkg::SEL_NONE) |-> !s_tready)
        else $error("byte emitted while idle");

endmodule
`default_nettype wire
